// ----- sv/lop_pkg.sv -----
`timescale 1ns / 1ps

package lop_pkg;

	localparam int COORD_W    = 16;
	localparam int SPAN_W     = 15;
	localparam int ACT_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int GAP_Q4     = 64;

	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_LEFT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_TOP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_SPAN_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_SPAN_Y = 2'd3;

	localparam logic [COORD_W-1:0] VIEW_LEFT_RST   = 16'd0;
	localparam logic [COORD_W-1:0] VIEW_TOP_RST    = 16'd0;
	localparam logic [SPAN_W-1:0]  VIEW_SPAN_X_RST = 15'd20480;
	localparam logic [SPAN_W-1:0]  VIEW_SPAN_Y_RST = 15'd11520;

	typedef struct packed {
		logic [ACT_W-1:0]          action;
		logic signed [COORD_W-1:0] rect_left;
		logic signed [COORD_W-1:0] rect_top;
		logic [SPAN_W-1:0]         rect_span_x;
		logic [SPAN_W-1:0]         rect_span_y;
	} in_item_t;

	typedef struct packed {
		logic                      found;
		logic signed [COORD_W-1:0] place_left;
		logic signed [COORD_W-1:0] place_top;
	} out_item_t;

	typedef struct packed {
		logic [SPAN_W-1:0]         span_y;
		logic [SPAN_W-1:0]         span_x;
		logic signed [COORD_W-1:0] top;
		logic signed [COORD_W-1:0] left;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic setup;
		logic exec;
		logic row_next;
		logic scan_start;
		logic scan_next;
		logic res_zero;
		logic res_found;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             reject;
		logic             row_ok;
		logic             last_step;
		logic             n_zero;
		logic             hit;
		logic             last_entry;
	} dp_sts_t;

endpackage

// ----- sv/lop_ctrl.sv -----
`timescale 1ns / 1ps

module lop_ctrl
	import lop_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_ROW  = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (sts.act == ACT_QUERY) begin
					if (sts.reject) begin
						cmd.res_zero = 1'b1;
						state_d      = ST_DONE;
					end else begin
						cmd.setup = 1'b1;
						state_d   = ST_ROW;
					end
				end else begin
					cmd.exec = 1'b1;
					state_d  = ST_DONE;
				end
			end
			ST_ROW: begin
				if (!sts.row_ok) begin
					if (sts.last_step) begin
						cmd.res_zero = 1'b1;
						state_d      = ST_DONE;
					end else begin
						cmd.row_next = 1'b1;
					end
				end else if (sts.n_zero) begin
					cmd.res_found = 1'b1;
					state_d       = ST_DONE;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.hit) begin
					if (sts.last_step) begin
						cmd.res_zero = 1'b1;
						state_d      = ST_DONE;
					end else begin
						cmd.row_next = 1'b1;
						state_d      = ST_ROW;
					end
				end else if (sts.last_entry) begin
					cmd.res_found = 1'b1;
					state_d       = ST_DONE;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_LOAD))
		else $error("accepted request did not enter load");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result shown outside done");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !out_ready) |=> (state_q == ST_DONE))
		else $error("result overwrote a pending one");

endmodule

// ----- sv/lop_dp.sv -----
`timescale 1ns / 1ps

module lop_dp
	import lop_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_item_t              in_data,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	output out_item_t             out_data
);

	localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int STEP_W = $clog2(2 * TABLE_DEPTH + 3);
	localparam int CW     = 20;
	localparam int OFF_W  = 17;

	localparam logic signed [CW-1:0] GAP_S = CW'(GAP_Q4);
	localparam logic signed [CW-1:0] MIN_S = CW'(-32768);
	localparam logic signed [CW-1:0] MAX_S = CW'(32767);

	logic [COORD_W-1:0] view_left_q;
	logic [COORD_W-1:0] view_top_q;
	logic [SPAN_W-1:0]  view_span_x_q;
	logic [SPAN_W-1:0]  view_span_y_q;

	logic [CNT_W-1:0]   count_q;
	entry_t             table_q [TABLE_DEPTH];
	entry_t             rd_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   idx_d;
	logic [STEP_W-1:0]  step_q;
	logic [OFF_W-1:0]   off_q;
	logic [OFF_W:0]     off_sum;
	logic [OFF_W-1:0]   off_next;

	in_item_t           req_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic signed [CW-1:0] bottom_q;
	logic [COORD_W-1:0] pitch_q;
	out_item_t          res_q;
	out_item_t          out_q;
	out_item_t          exec_res;

	logic signed [CW-1:0] vl_w, vt_w, vsx_w, vsy_w;
	logic signed [CW-1:0] rx_w, ry_w, rw_w, rh_w;
	logic signed [CW-1:0] xmax_w, bottom_w, xc_a, xc_w, yc_a, yc_w;
	logic signed [CW-1:0] x_w, y_w, off_w, cy_w;
	logic signed [CW-1:0] px_w, py_w, pw_w, ph_w;
	logic [STEP_W-1:0]    step_last;
	logic                 room;
	entry_t               new_entry;

	assign vl_w  = CW'($signed(view_left_q));
	assign vt_w  = CW'($signed(view_top_q));
	assign vsx_w = CW'(view_span_x_q);
	assign vsy_w = CW'(view_span_y_q);
	assign rx_w  = CW'($signed(req_q.rect_left));
	assign ry_w  = CW'($signed(req_q.rect_top));
	assign rw_w  = CW'(req_q.rect_span_x);
	assign rh_w  = CW'(req_q.rect_span_y);

	// clamp the request into the viewport
	assign xmax_w   = vl_w + vsx_w - rw_w;
	assign bottom_w = vt_w + vsy_w - rh_w;
	assign xc_a     = (rx_w > xmax_w) ? xmax_w : rx_w;
	assign xc_w     = (xc_a < vl_w) ? vl_w : xc_a;
	assign yc_a     = (ry_w > bottom_w) ? bottom_w : ry_w;
	assign yc_w     = (yc_a < vt_w) ? vt_w : yc_a;

	// candidate row: odd steps above the anchor, even steps below
	assign x_w   = CW'($signed(x_q));
	assign y_w   = CW'($signed(y_q));
	assign off_w = CW'(off_q);
	assign cy_w  = step_q[0] ? (y_w - off_w) : (y_w + off_w);

	assign px_w = CW'($signed(rd_q.left));
	assign py_w = CW'($signed(rd_q.top));
	assign pw_w = CW'(rd_q.span_x);
	assign ph_w = CW'(rd_q.span_y);

	assign off_sum  = {1'b0, off_q} + (OFF_W + 1)'(pitch_q);
	assign off_next = off_sum[OFF_W] ? '1 : off_sum[OFF_W-1:0];

	assign step_last = STEP_W'({count_q, 1'b0}) + STEP_W'(2);
	assign room      = (count_q < CNT_W'(TABLE_DEPTH));

	assign new_entry.left   = req_q.rect_left;
	assign new_entry.top    = req_q.rect_top;
	assign new_entry.span_x = req_q.rect_span_x;
	assign new_entry.span_y = req_q.rect_span_y;

	assign sts.act    = req_q.action;
	assign sts.reject = (req_q.rect_span_x == '0) || (req_q.rect_span_y == '0) ||
		(req_q.rect_span_x > view_span_x_q) || (req_q.rect_span_y > view_span_y_q);
	assign sts.row_ok = (cy_w >= vt_w) && (cy_w <= bottom_q) &&
		(cy_w >= MIN_S) && (cy_w <= MAX_S);
	assign sts.last_step  = (step_q == step_last);
	assign sts.n_zero     = (count_q == '0);
	assign sts.last_entry = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign sts.hit = (rd_q.span_x != '0) && (rd_q.span_y != '0) &&
		(x_w < px_w + pw_w + GAP_S) && (x_w + rw_w + GAP_S > px_w) &&
		(cy_w < py_w + ph_w + GAP_S) && (cy_w + rh_w + GAP_S > py_w);

	assign out_data = out_q;

	always_comb begin
		if (cmd.scan_start) begin
			idx_d = '0;
		end else if (cmd.scan_next) begin
			idx_d = idx_q + IDX_W'(1);
		end else begin
			idx_d = idx_q;
		end
	end

	always_comb begin
		exec_res = '0;
		unique case (req_q.action)
			ACT_CLEAR:  exec_res.found = 1'b1;
			ACT_APPEND: exec_res.found = room;
			ACT_QUERY:  exec_res.found = 1'b0;
			ACT_NONE:   exec_res.found = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_left_q   <= VIEW_LEFT_RST;
			view_top_q    <= VIEW_TOP_RST;
			view_span_x_q <= VIEW_SPAN_X_RST;
			view_span_y_q <= VIEW_SPAN_Y_RST;
			count_q       <= '0;
			step_q        <= '0;
			off_q         <= '0;
			idx_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_VIEW_LEFT:   view_left_q   <= cfg_data;
					CFG_VIEW_TOP:    view_top_q    <= cfg_data;
					CFG_VIEW_SPAN_X: view_span_x_q <= cfg_data[SPAN_W-1:0];
					CFG_VIEW_SPAN_Y: view_span_y_q <= cfg_data[SPAN_W-1:0];
				endcase
			end
			if (cmd.exec) begin
				if (req_q.action == ACT_CLEAR) begin
					count_q <= '0;
				end else if (req_q.action == ACT_APPEND && room) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.setup) begin
				step_q <= '0;
				off_q  <= '0;
			end else if (cmd.row_next) begin
				step_q <= step_q + STEP_W'(1);
				if (!step_q[0]) begin
					off_q <= off_next;
				end
			end
			idx_q <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= in_data;
		end
		if (cmd.setup) begin
			x_q      <= xc_w[COORD_W-1:0];
			y_q      <= yc_w[COORD_W-1:0];
			bottom_q <= bottom_w;
			pitch_q  <= {1'b0, req_q.rect_span_y} + COORD_W'(GAP_Q4);
		end
		if (cmd.exec && req_q.action == ACT_APPEND && room) begin
			table_q[count_q[IDX_W-1:0]] <= new_entry;
		end
		rd_q <= table_q[idx_d];
		if (cmd.exec) begin
			res_q <= exec_res;
		end else if (cmd.res_zero) begin
			res_q <= '0;
		end else if (cmd.res_found) begin
			res_q <= '{found: 1'b1, place_left: x_q, place_top: cy_w[COORD_W-1:0]};
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_next |-> ((CNT_W'(idx_q) + CNT_W'(1)) < count_q))
		else $error("scan past last stored entry");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && req_q.action == ACT_APPEND && !room) |=> $stable(count_q))
		else $error("append to full table changed count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("stored count above table depth");

endmodule

// ----- sv/label_overlap_placer_unit.sv -----
`timescale 1ns / 1ps
// clear, append and rejected query: the request is captured, the load state registers the result, done loads it out
// query: after load it steps through candidate rows, comparing each row with the stored entries one at a time,
//   and tries at most 2n+3 candidate rows with n stored entries
// throughput: one request at a time, the next is taken once the result sits in the output
//   register; a single overlap comparator reads one table entry a cycle during the scan
// reset: asynchronous active low, clears count and control, sets viewport registers to defaults; table undefined
module label_overlap_placer_unit
	import lop_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	lop_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lop_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule
